@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication or plain property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ rtl/nwss_pkg.sv @@
// ----------------------------------------------------------------------------
// nwss_pkg
// Constants, codes and the sigmoid table generator of the neuron block.
// ----------------------------------------------------------------------------
package nwss_pkg;

  // Item kind carried on the input tuser bit.
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  localparam int unsigned SIG_ENTRIES = 256;
  localparam int unsigned SIG_IDX_W   = $clog2(SIG_ENTRIES);

  localparam int unsigned VAL_W  = 16;  // Q4.12 sample and weight
  localparam int unsigned PROD_W = 32;  // Q8.24 product
  localparam int unsigned SUM_W  = 38;  // Q14.24 running sum
  localparam int unsigned POS_W  = 6;
  localparam int unsigned OFF_W  = 28;  // activation offset in [0, 2^28)

  localparam logic signed [SUM_W-1:0] ACT_HI = 38'sd134217727;
  localparam logic signed [SUM_W-1:0] ACT_LO = -38'sd134217728;

  // Unsigned quotient by shift and subtract; it is only used while the
  // sigmoid table is built.
  function automatic longint unsigned udiv_u64(input longint unsigned dividend,
                                                input longint unsigned divisor);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], dividend[i]};
      if (rem >= divisor) begin
        rem    = rem - divisor;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One sigmoid table entry, evaluated at elaboration. The bin center is
  // taken in Q.30, exp(-|x|) is built from a Taylor series of exp(-|x|/8)
  // squared three times, and the result is scaled to Q4.12 rounded half up.
  function automatic logic [15:0] sig_entry(input int unsigned k);
    longint unsigned off;
    longint unsigned eight;
    longint unsigned mag;
    longint unsigned u;
    longint unsigned term;
    longint unsigned r;
    longint unsigned den;
    longint unsigned num;
    longint unsigned q;
    longint          acc;
    bit              neg;
    off   = ((2 * longint'(k) + 1) * (64'd8 << 30)) >> SIG_IDX_W;
    eight = 64'd8 << 30;
    neg   = off < eight;
    mag   = neg ? eight - off : off - eight;
    u     = mag >> 3;
    term  = 64'd1 << 30;
    acc   = longint'(64'd1 << 30);
    for (int unsigned n = 1; n <= 20; n++) begin
      term = udiv_u64((term * u) >> 30, longint'(n));
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = longint'(acc);
    for (int unsigned i = 0; i < 3; i++) begin
      r = (r * r + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + r;
    num = neg ? r : (64'd1 << 30);
    q   = udiv_u64(num * 64'd8192 + den, 2 * den);
    return q[15:0];
  endfunction

endpackage

@@ rtl/neuron_weighted_sum_sigmoid.sv @@
// ----------------------------------------------------------------------------
// neuron_weighted_sum_sigmoid
// Single fixed-point neuron: weight memory, multiply-accumulate, sigmoid table.
// ----------------------------------------------------------------------------
// The block takes one item per clock while its output is not stalled and
// is fully pipelined: a load item (tuser = 0) writes its Q4.12 weight into
// the weight memory at the given position, and a sample item (tuser = 1)
// reads the weight at its position, multiplies it by the sample and adds the
// Q8.24 product to a saturating 38-bit running sum. The sample marked by
// tlast also produces one result item: the sum clamped to [-8, 8), looked
// up in a 256-entry sigmoid table (Q4.12, 0 to 4096), with tuser high when
// the clamp acted; the sum is then cleared. With the is_input_layer register
// set, every sample is returned as it came in and the sum is left alone. On
// its way to the output a sample passes the weight read at the edge that
// accepts it, then the product register, the accumulate into the stage-3
// register and the table lookup into the output register. Loads, non-last
// samples and results all sustain one item per cycle while the output is
// not stalled; the rate is set by the accumulate loop around the running-sum
// register. A weight must be loaded before a sample reads it. The
// configuration register may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module neuron_weighted_sum_sigmoid
  import nwss_pkg::*;
#(
  parameter int unsigned MAX_INPUTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write channel: is_input_layer in bit 0.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,

  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [5:0] position, [21:6] value, [23:22] zero
  input  logic        s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,

  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] neuron_result
  output logic        m_axis_tuser    // [0] activation_clamped
);

  `include "assert_macros.svh"

  localparam int unsigned AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned EW = (AW > POS_W) ? AW : POS_W;

  // Configuration register.
  logic is_input_layer_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_input_layer_q <= 1'b0;
    end else if (cfg_valid_i) begin
      is_input_layer_q <= cfg_data_i;
    end
  end

  // Input unpacking.
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_value;
  logic [EW-1:0]           pos_ext;
  logic [AW-1:0]           mem_addr;
  logic                    in_range;
  logic                    accept;
  logic                    is_sample;

  assign in_pos    = s_axis_tdata[POS_W-1:0];
  assign in_value  = $signed(s_axis_tdata[POS_W +: VAL_W]);
  assign pos_ext   = EW'(in_pos);
  assign mem_addr  = pos_ext[AW-1:0];
  assign in_range  = (32'(in_pos) < MAX_INPUTS);
  assign is_sample = (action_e'(s_axis_tuser) == ACT_SAMPLE);

  // Pipeline occupancy and flow control. Each stage moves on when the one
  // after it is empty or moving, so bubbles fill under a stalled output.
  logic v1_q, v2_q, v3_q, out_v_q;
  logic en_out, en3, en2, en1;
  logic fire2;

  assign en_out = !out_v_q || m_axis_tready;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign fire2  = v2_q && en3;

  assign s_axis_tready = en1;
  assign accept        = s_axis_tvalid && en1;

  // Weight memory: written by loads, read by samples, one access per item.
  logic [VAL_W-1:0] wmem [MAX_INPUTS];
  logic [VAL_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!is_sample && in_range) begin
        wmem[mem_addr] <= in_value;
      end
      rd_q <= wmem[mem_addr];
    end
  end

  // Stage 1: weight read in flight.
  logic signed [VAL_W-1:0] s1_value_q;
  logic                    s1_last_q, s1_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= accept && is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_value_q <= in_value;
      s1_last_q  <= s_axis_tlast;
      s1_range_q <= in_range;
    end
  end

  // Stage 2: product registered.
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [VAL_W-1:0]  s2_value_q;
  logic                     s2_last_q, s2_range_q;

  assign prod_d = $signed(rd_q) * s1_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prod_q     <= prod_d;
      s2_value_q <= s1_value_q;
      s2_last_q  <= s1_last_q;
      s2_range_q <= s1_range_q;
    end
  end

  // Accumulate with saturation at the 38-bit signed limits.
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W-1:0] prod_ext;
  logic signed [SUM_W:0]   add_full;
  logic signed [SUM_W-1:0] add_sat;
  logic signed [SUM_W-1:0] acc_new;

  assign prod_ext = SUM_W'(prod_q);
  assign add_full = {sum_q[SUM_W-1], sum_q} + {prod_ext[SUM_W-1], prod_ext};

  always_comb begin
    if (add_full[SUM_W] != add_full[SUM_W-1]) begin
      add_sat = add_full[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      add_sat = add_full[SUM_W-1:0];
    end
  end

  assign acc_new = s2_range_q ? add_sat : sum_q;

  always_comb begin
    sum_d = sum_q;
    if (fire2 && !is_input_layer_q) begin
      sum_d = s2_last_q ? '0 : acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Stage 3: final activation or pass-through sample, waiting for lookup.
  logic signed [SUM_W-1:0] fin_q;
  logic signed [VAL_W-1:0] s3_value_q;
  logic                    s3_pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q && (s2_last_q || is_input_layer_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire2) begin
      fin_q      <= acc_new;
      s3_value_q <= s2_value_q;
      s3_pass_q  <= is_input_layer_q;
    end
  end

  // Clamp to [-8, 8) and index the sigmoid table.
  logic [15:0]              sig_rom [SIG_ENTRIES];
  logic signed [SUM_W-1:0]  clamped;
  logic signed [SUM_W-1:0]  off_full;
  logic [OFF_W+SIG_IDX_W:0] idx_prod;
  logic [SIG_IDX_W-1:0]     sig_idx;
  logic                     clamp_hi, clamp_lo;
  logic signed [VAL_W-1:0]  res_d;
  logic                     flag_d;

  for (genvar k = 0; k < SIG_ENTRIES; k++) begin : g_sig_rom
    assign sig_rom[k] = sig_entry(k);
  end

  assign clamp_hi = fin_q > ACT_HI;
  assign clamp_lo = fin_q < ACT_LO;
  assign clamped  = clamp_hi ? ACT_HI : (clamp_lo ? ACT_LO : fin_q);
  assign off_full = clamped - ACT_LO;
  assign idx_prod = {{(SIG_IDX_W+1){1'b0}}, off_full[OFF_W-1:0]}
                    * (OFF_W+SIG_IDX_W+1)'(SIG_ENTRIES);
  assign sig_idx  = idx_prod[OFF_W +: SIG_IDX_W];

  assign res_d  = s3_pass_q ? s3_value_q : $signed(sig_rom[sig_idx]);
  assign flag_d = !s3_pass_q && (clamp_hi || clamp_lo);

  // Output register.
  logic signed [VAL_W-1:0] out_res_q;
  logic                    out_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && v3_q) begin
      out_res_q  <= res_d;
      out_flag_q <= flag_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_res_q;
  assign m_axis_tuser  = out_flag_q;

  // Assertions.
  `ASSERT_PROP(a_sum_cleared_after_last, clk_i, rst_ni,
               (fire2 && s2_last_q && !is_input_layer_q) |=> (sum_q == '0))
  `ASSERT_PROP(a_sum_held_when_idle, clk_i, rst_ni, (!fire2) |=> $stable(sum_q))
  `ASSERT_PROP(a_sigmoid_in_range, clk_i, rst_ni,
               (v3_q && !s3_pass_q) |-> (res_d >= 0 && res_d <= 16'sd4096))
  `ASSERT_NEVER(a_stall_needs_occupant, clk_i, rst_ni, !s_axis_tready && !v1_q)

endmodule
